// File: src/ckti_pkg.sv
// Package: shared types and constants of the clamped knot-table interpolator.
`default_nettype none
package ckti_pkg;

  localparam int LAT_W     = 24;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int REGION_W  = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = 5;
  localparam int LANES     = 2;

  localparam logic [COUNT_W-1:0] KNOT_COUNT_RESET = 7'd2;

  // register index, taken from paddr[2]
  localparam logic REG_KNOT_COUNT = 1'b0;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [REGION_W-1:0] REGION_INTERP = 2'd0;
  localparam logic [REGION_W-1:0] REGION_SOUTH  = 2'd1;
  localparam logic [REGION_W-1:0] REGION_NORTH  = 2'd2;

  typedef struct packed {
    logic                    mode;
    logic [IDX_W-1:0]        knot_index;
    logic signed [LAT_W-1:0] knot_latitude;
    logic signed [VAL_W-1:0] knot_world_value;
    logic signed [VAL_W-1:0] knot_regional_value;
    logic signed [LAT_W-1:0] query_latitude;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] world_result;
    logic signed [VAL_W-1:0] regional_result;
    logic [REGION_W-1:0]     region;
  } out_item_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [VAL_W-1:0] world;
    logic signed [VAL_W-1:0] regional;
  } knot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_CHECK,
    ST_SCAN,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: src/ckti_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ckti_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/clamped_knot_table_interpolator.sv
// Top level: clamped piecewise-linear interpolator over a table of latitude knots.
`default_nettype none
// Keeps up to MAX_KNOTS knots (latitude Q8.16, two Q16.16 value channels) in one
// synchronous RAM. A load transaction (mode 0) writes one knot and produces no
// result; loads with knot_index >= MAX_KNOTS are dropped. A query transaction
// (mode 1) produces exactly one result. The table is read back through the RAM's
// single read port, one entry per cycle: entry 0, then the last knot in use, then a
// scan upward from knot 1 that stops at the first knot above the query (or at the
// last knot). Below the first knot the result is knot 0 (region 1); above the last
// knot it is the last knot (region 2). Otherwise both channels are interpolated in
// parallel lanes: first the differences, then a 32x24 multiply, a radix-2 restoring
// divide, the add-back of the lower value and the hand-over of the result. A zero
// knot spacing returns the lower knot.
// Queries are worked one at a time; item_stall is high while a query is in progress.
// A finished result sits in an output register, so the next transaction is taken while
// it waits on result_stall. knot_count (APB address 0, reset 2) is clamped into
// [2, MAX_KNOTS] and must only be written while the block is idle. Table entries are
// not cleared by reset; a query that touches a never-written knot returns garbage.
module clamped_knot_table_interpolator #(
  parameter int MAX_KNOTS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input transactions
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire ckti_pkg::in_item_t                  item,
  // result transactions
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output ckti_pkg::out_item_t                      result,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ckti_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [ckti_pkg::PDATA_W-1:0]        pwdata,
  output logic      [ckti_pkg::PDATA_W-1:0]        prdata,
  output logic                                     pready
);

  import ckti_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] knot_count;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_KNOT_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= KNOT_COUNT_RESET;
    end else if (cfg_write) begin
      knot_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KNOT_COUNT) begin
      prdata = {{(PDATA_W-COUNT_W){1'b0}}, knot_count};
    end
  end

  // index of the last knot in use, count clamped into [2, MAX_KNOTS]
  logic [AW-1:0] last_idx;

  always_comb begin
    if (knot_count < 7'd2) begin
      last_idx = AW'(1);
    end else if (32'(knot_count) > MAX_KNOTS) begin
      last_idx = AW'(MAX_KNOTS - 1);
    end else begin
      last_idx = AW'(32'(knot_count) - 32'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Knot memory
  // ---------------------------------------------------------------------------
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  knot_t             mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [$bits(knot_t)-1:0] mem_rdata;
  knot_t             rd_k;

  assign mem_waddr = AW'(item.knot_index);
  assign mem_wdata = '{lat:      item.knot_latitude,
                       world:    item.knot_world_value,
                       regional: item.knot_regional_value};
  assign rd_k      = knot_t'(mem_rdata);

  ckti_ram #(
    .WIDTH($bits(knot_t)),
    .DEPTH(MAX_KNOTS)
  ) u_knot_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic               item_acc;
  logic               is_query;
  logic               load_ok;

  logic signed [LAT_W-1:0] q;          // query latitude under work
  knot_t              lo_k;            // lower knot (entry 0 until the scan moves it)
  knot_t              hi_k;            // upper knot
  logic [AW-1:0]      rk;              // index of the entry on the read data bus
  logic [LAT_W-1:0]   span;            // hi - lo latitude, never negative here
  logic [LAT_W-1:0]   t;               // q - lo latitude, 0 .. span
  logic [VAL_W-1:0]   ad   [LANES];    // |v1 - v0| per lane
  logic               neg  [LANES];
  logic [LAT_W-1:0]   rem  [LANES];
  logic [VAL_W-1:0]   quo  [LANES];
  logic [STEP_W-1:0]  step;
  logic [VAL_W-1:0]   res_v [LANES];
  logic [REGION_W-1:0] res_region;

  logic               south, north, found, span_zero, div_last, out_free;
  logic signed [LAT_W:0] span_w, t_w;

  assign item_acc  = item_valid && !item_stall;
  assign is_query  = (item.mode == MODE_QUERY);
  assign load_ok   = 32'(item.knot_index) < MAX_KNOTS;
  assign south     = q < lo_k.lat;
  assign north     = q > rd_k.lat;
  assign found     = (rd_k.lat > q) || (rk == last_idx);
  assign span_w    = {hi_k.lat[LAT_W-1], hi_k.lat} - {lo_k.lat[LAT_W-1], lo_k.lat};
  assign t_w       = {q[LAT_W-1], q} - {lo_k.lat[LAT_W-1], lo_k.lat};
  assign span_zero = (span_w == '0);
  assign div_last  = (step == STEP_W'(DIV_STEPS - 1));
  assign out_free  = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        mem_raddr  = '0;
        if (item_acc) begin
          if (is_query) begin
            state_next = ST_RD_LAST;
          end else begin
            mem_we = load_ok;
          end
        end
      end
      ST_RD_LAST: begin
        mem_raddr  = last_idx;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        mem_raddr = AW'(1);
        if (south || north) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        mem_raddr = rk + AW'(1);
        if (found) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = span_zero ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Per-lane arithmetic: lane 0 is the world channel, lane 1 the regional one
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0]      lo_v   [LANES];
  logic [VAL_W-1:0]      hi_v   [LANES];
  logic signed [VAL_W:0] diff   [LANES];
  logic [VAL_W:0]        diff_n [LANES];
  logic [VAL_W+LAT_W-1:0] prod  [LANES];
  logic [LAT_W:0]        trial  [LANES];
  logic [LAT_W:0]        tsub   [LANES];
  logic                  ge     [LANES];
  logic [VAL_W:0]        sq     [LANES];
  logic [VAL_W:0]        sum    [LANES];

  assign lo_v[0] = lo_k.world;
  assign lo_v[1] = lo_k.regional;
  assign hi_v[0] = hi_k.world;
  assign hi_v[1] = hi_k.regional;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      diff[l]   = {hi_v[l][VAL_W-1], hi_v[l]} - {lo_v[l][VAL_W-1], lo_v[l]};
      diff_n[l] = ~diff[l] + 1'b1;
      prod[l]   = {{LAT_W{1'b0}}, ad[l]} * {{VAL_W{1'b0}}, t};
      trial[l]  = {rem[l], quo[l][VAL_W-1]};
      tsub[l]   = trial[l] - {1'b0, span};
      ge[l]     = trial[l] >= {1'b0, span};
      sq[l]     = neg[l] ? (~{1'b0, quo[l]} + 1'b1) : {1'b0, quo[l]};
      sum[l]    = {lo_v[l][VAL_W-1], lo_v[l]} + sq[l];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        q <= item.query_latitude;
      end
      ST_RD_LAST: begin
        lo_k <= rd_k;                         // entry 0
      end
      ST_CHECK: begin
        rk <= AW'(1);
        if (south) begin
          res_v[0]   <= lo_k.world;
          res_v[1]   <= lo_k.regional;
          res_region <= REGION_SOUTH;
        end else if (north) begin
          res_v[0]   <= rd_k.world;           // last knot in use
          res_v[1]   <= rd_k.regional;
          res_region <= REGION_NORTH;
        end
      end
      ST_SCAN: begin
        if (found) begin
          hi_k <= rd_k;
        end else begin
          lo_k <= rd_k;
          rk   <= rk + AW'(1);
        end
      end
      ST_PREP: begin
        span       <= span_w[LAT_W-1:0];
        t          <= t_w[LAT_W-1:0];
        res_region <= REGION_INTERP;
        res_v[0]   <= lo_k.world;             // kept when the spacing is zero
        res_v[1]   <= lo_k.regional;
        for (int l = 0; l < LANES; l++) begin
          neg[l] <= diff[l][VAL_W];
          ad[l]  <= diff[l][VAL_W] ? diff_n[l][VAL_W-1:0] : diff[l][VAL_W-1:0];
        end
      end
      ST_MUL: begin
        step <= '0;
        // quotient < 2^32, so the top bits start below span
        for (int l = 0; l < LANES; l++) begin
          rem[l] <= prod[l][VAL_W+LAT_W-1:VAL_W];
          quo[l] <= prod[l][VAL_W-1:0];
        end
      end
      ST_DIV: begin
        step <= step + 1'b1;
        for (int l = 0; l < LANES; l++) begin
          rem[l] <= ge[l] ? tsub[l][LAT_W-1:0] : trial[l][LAT_W-1:0];
          quo[l] <= {quo[l][VAL_W-2:0], ge[l]};
        end
      end
      ST_FIX: begin
        for (int l = 0; l < LANES; l++) begin
          res_v[l] <= sum[l][VAL_W-1:0];
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      result.world_result    <= res_v[0];
      result.regional_result <= res_v[1];
      result.region          <= res_region;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a query holds off the next transaction
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.mode == MODE_QUERY) |=> item_stall)
    else $error("input taken right after a query");

  // a load leaves the input free in the next cycle
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.mode == MODE_LOAD) |=> !item_stall)
    else $error("load transaction stalled the input");

  // restoring divider invariant
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem[0] < span) && (rem[1] < span))
    else $error("divider remainder out of range");

  // region code stays in its defined set
  a_region: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.region == REGION_INTERP || result.region == REGION_SOUTH ||
                      result.region == REGION_NORTH))
    else $error("undefined region code");

endmodule
`default_nettype wire

// File: tb/clamped_knot_table_interpolator_tb.sv
// Testbench for the clamped knot-table interpolator: directed and random loads and queries checked on the fly.
`default_nettype none
module clamped_knot_table_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckti_pkg::*;

  localparam int MAX_KNOTS    = 64;
  localparam int LAT_LIMIT    = 5898240;       // +/-90 degrees in Q8.16
  localparam int RANDOM_ITEMS = 1200;
  // Long enough for any query over the full table, or any load, to finish.
  localparam int DRAIN_CYCLES = 110;
  // Worst case per transaction: a full query, the longest input gap and the
  // longest result stall. The limit covers about 1300 such transactions
  // several times over.
  localparam int CYCLE_LIMIT  = 3_000_000;

  localparam logic [PADDR_W-1:0] KNOT_COUNT_ADDR = {REG_KNOT_COUNT, 2'b00};
  localparam logic [VAL_W-1:0]   VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0]   VAL_MAX = 32'h7FFF_FFFF;

  logic clk;
  logic rst = 1'b1;

  logic                item_valid = 1'b0;
  logic                item_stall;
  in_item_t            item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  out_item_t           result;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  clamped_knot_table_interpolator #(
    .MAX_KNOTS(MAX_KNOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Transactions waiting for the driver, and results the block still owes.
  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  // Shadow of the block's table and its knot_count register.
  logic signed [LAT_W-1:0] lat_tab      [MAX_KNOTS];
  logic signed [VAL_W-1:0] world_tab    [MAX_KNOTS];
  logic signed [VAL_W-1:0] regional_tab [MAX_KNOTS];
  logic [COUNT_W-1:0]      knot_count_cfg = KNOT_COUNT_RESET;

  // Latitudes as the stimulus generator has planned them; used to aim queries.
  int plan_lat [MAX_KNOTS];

  int  random_items = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;       // no gaps and no stalls while set
  int  gap_left = 0;
  int  stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Register value as the block uses it: clamped into [2, MAX_KNOTS].
  function automatic int used_knots(input logic [COUNT_W-1:0] cfg);
    int n;
    n = int'(cfg);
    if (n < 2) n = 2;
    if (n > MAX_KNOTS) n = MAX_KNOTS;
    return n;
  endfunction

  // Exact product first, then a division truncating toward zero.
  function automatic longint lerp(input longint v0, v1, l0, l1, q);
    longint span;
    span = l1 - l0;
    if (span == 0) return v0;
    return v0 + ((v1 - v0) * (q - l0)) / span;
  endfunction

  function automatic out_item_t predict_query(input logic signed [LAT_W-1:0] q_lat);
    out_item_t res;
    int        n, hi;
    longint    q, w, r;
    n  = used_knots(knot_count_cfg);
    q  = longint'(q_lat);
    hi = n - 1;
    // First knot above the query; the last knot in use if none is.
    for (int k = 1; k < n; k++) begin
      if (longint'(lat_tab[k]) > q) begin
        hi = k;
        break;
      end
    end
    if (q < longint'(lat_tab[0])) begin
      w = world_tab[0];
      r = regional_tab[0];
      res.region = REGION_SOUTH;
    end else if (q > longint'(lat_tab[n-1])) begin
      w = world_tab[n-1];
      r = regional_tab[n-1];
      res.region = REGION_NORTH;
    end else begin
      w = lerp(world_tab[hi-1], world_tab[hi], lat_tab[hi-1], lat_tab[hi], q);
      r = lerp(regional_tab[hi-1], regional_tab[hi], lat_tab[hi-1], lat_tab[hi], q);
      res.region = REGION_INTERP;
    end
    res.world_result    = w[VAL_W-1:0];
    res.regional_result = r[VAL_W-1:0];
    return res;
  endfunction

  // Called for every accepted transaction, in acceptance order.
  function automatic void apply_transaction(input in_item_t it);
    if (it.mode == MODE_LOAD) begin
      if (int'(it.knot_index) < MAX_KNOTS) begin
        lat_tab[it.knot_index]      = it.knot_latitude;
        world_tab[it.knot_index]    = it.knot_world_value;
        regional_tab[it.knot_index] = it.knot_regional_value;
      end
    end else begin
      expected_results.push_back(predict_query(it.query_latitude));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none, some short, a few long.
  // ---------------------------------------------------------------------------
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds pending_items, holds the payload while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (item_valid && !item_stall) apply_transaction(item);
      // Free to move on when nothing is offered or the offer was taken.
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
          gap_left   <= quiet ? 0 : pick_idle_len();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random result stalls, field-by-field compare against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: world %0d regional %0d region %0d",
               $time, got.world_result, got.regional_result, got.region);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (got.world_result !== want.world_result) begin
      $display("%0t: world_result expected %0d actual %0d",
               $time, want.world_result, got.world_result);
      mismatches++;
    end
    if (got.regional_result !== want.regional_result) begin
      $display("%0t: regional_result expected %0d actual %0d",
               $time, want.regional_result, got.regional_result);
      mismatches++;
    end
    if (got.region !== want.region) begin
      $display("%0t: region expected %0d actual %0d", $time, want.region, got.region);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        result_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left   <= pick_idle_len();
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int rand_latitude();
    return int'($urandom_range(0, 2 * LAT_LIMIT)) - LAT_LIMIT;
  endfunction

  // Full-scale values turn up often so the widest products get exercised.
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return VAL_MIN;
    if (r < 20) return VAL_MAX;
    if (r < 25) return '0;
    return $urandom;
  endfunction

  // Unused fields of every transaction carry random data.
  task automatic push_load(input int idx, input int lat,
                           input logic [VAL_W-1:0] w, input logic [VAL_W-1:0] r);
    in_item_t it;
    it.mode                = MODE_LOAD;
    it.knot_index          = IDX_W'(idx);
    it.knot_latitude       = LAT_W'(lat);
    it.knot_world_value    = w;
    it.knot_regional_value = r;
    it.query_latitude      = LAT_W'(rand_latitude());
    plan_lat[idx % MAX_KNOTS] = lat;
    pending_items.push_back(it);
    random_items++;
  endtask

  task automatic push_query(input int q);
    in_item_t it;
    it.mode                = MODE_QUERY;
    it.knot_index          = IDX_W'($urandom);
    it.knot_latitude       = LAT_W'(rand_latitude());
    it.knot_world_value    = $urandom;
    it.knot_regional_value = $urandom;
    it.query_latitude      = LAT_W'(q);
    pending_items.push_back(it);
    random_items++;
  endtask

  // Well-formed ascending table over slots 0..n-1. Zero steps give equal
  // neighbors; a capped step gives narrow spans.
  task automatic load_table(input int n);
    int lat, step_max;
    if ($urandom_range(0, 9) < 7) lat = -LAT_LIMIT + int'($urandom_range(0, 1000000));
    else lat = rand_latitude();
    step_max = (LAT_LIMIT - lat) / (n - 1);
    if ($urandom_range(0, 9) < 3 && step_max > 50) step_max = 50;
    for (int i = 0; i < n; i++) begin
      push_load(i, lat, pick_value(), pick_value());
      if (i < n - 1 && $urandom_range(0, 9) != 0) lat += int'($urandom_range(0, step_max));
    end
  endtask

  // Queries aimed below, above, at and near knots, at +/-LAT_LIMIT,
  // and inside the table.
  function automatic int pick_query_lat(input int n);
    int lo, top, r, q;
    lo  = plan_lat[0];
    top = plan_lat[n-1];
    r   = $urandom_range(0, 99);
    if (r < 10 && lo > -LAT_LIMIT)
      return -LAT_LIMIT + int'($urandom_range(0, lo - 1 + LAT_LIMIT));
    if (r < 20 && top < LAT_LIMIT)
      return top + 1 + int'($urandom_range(0, LAT_LIMIT - top - 1));
    if (r < 40) begin
      q = plan_lat[$urandom_range(0, n - 1)] + int'($urandom_range(0, 2)) - 1;
      if (q > LAT_LIMIT) q = LAT_LIMIT;
      if (q < -LAT_LIMIT) q = -LAT_LIMIT;
      return q;
    end
    if (r < 45) return ($urandom_range(0, 1) != 0) ? LAT_LIMIT : -LAT_LIMIT;
    if (lo < top) return lo + int'($urandom_range(0, top - lo));
    return rand_latitude();
  endfunction

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Block idle: nothing queued or offered, nothing owed, then enough cycles
  // for any load still in flight.
  task automatic settle();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned fixed_settings [6];
    int unsigned setting;
    int          n, ops, r, phase;

    fixed_settings = '{64, 0, 1, 127, 65, 3};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, knot_count at its reset value of 2.
    // Full-range knots with full-scale values of opposite sign.
    push_load(0, -LAT_LIMIT, VAL_MIN, VAL_MAX);
    push_load(1, LAT_LIMIT, VAL_MAX, VAL_MIN);
    push_load(MAX_KNOTS - 1, rand_latitude(), pick_value(), pick_value());
    push_query(-LAT_LIMIT);           // on the first knot
    push_query(LAT_LIMIT);            // on the last knot
    push_query(0);
    push_query(-1);
    push_query(1);
    // Narrow table: clamping on both sides, hits on the knots and a query inside.
    push_load(0, -100, pick_value(), pick_value());
    push_load(1, 100, pick_value(), pick_value());
    push_query(-LAT_LIMIT);
    push_query(LAT_LIMIT);
    push_query(-101);
    push_query(101);
    push_query(-100);
    push_query(100);
    push_query(37);
    // Two knots at the same latitude.
    push_load(0, 0, pick_value(), pick_value());
    push_load(1, 0, pick_value(), pick_value());
    push_query(0);
    push_query(-1);
    push_query(1);

    // Random phases. Each starts idle (so the sender waits for every owed
    // result), sets knot_count, loads a fresh ordered table and then mixes
    // queries with stray loads that may disorder the table.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      if (phase < 6) begin
        setting = fixed_settings[phase];
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) setting = $urandom_range(2, 8);
        else if (r < 75) setting = $urandom_range(9, MAX_KNOTS);
        else if (r < 85) setting = r[0] ? 2 : MAX_KNOTS;
        else if (r < 92) setting = $urandom_range(0, 1);
        else setting = $urandom_range(MAX_KNOTS + 1, 127);
      end
      apb_write(KNOT_COUNT_ADDR, PDATA_W'(setting));
      knot_count_cfg = COUNT_W'(setting);
      n = used_knots(knot_count_cfg);
      quiet = ($urandom_range(0, 4) == 0);
      load_table(n);
      ops = $urandom_range(20, 60);
      repeat (ops) begin
        if ($urandom_range(0, 99) < 15)
          push_load($urandom_range(0, MAX_KNOTS - 1), rand_latitude(),
                    pick_value(), pick_value());
        else
          push_query(pick_query_lat(n));
      end
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
